FILE: rtl/stcr_pkg.sv
package stcr_pkg;

	// fixed point
	localparam int FRAC_BITS  = 8;
	localparam int GAIN_FRAC  = 12;
	localparam int CORR_SHIFT = FRAC_BITS + GAIN_FRAC;
	localparam int US_PER_S   = 1000000;
	localparam int REM_W      = 20;

	// field widths
	localparam int TIME_W  = 32;
	localparam int RATE_W  = 16;
	localparam int STEP_W  = 20;
	localparam int RANGE_W = 15;
	localparam int ALT_W   = 21;
	localparam int GAIN_W  = 14;
	localparam int VLIM_W  = 10;
	localparam int TMO_W   = 16;
	localparam int BAND_W  = 14;
	localparam int CLIMB_W = 17;

	// datapath widths
	localparam int PROD_W     = RATE_W + STEP_W;
	localparam int DIV_W      = PROD_W + FRAC_BITS;
	localparam int BASE_W     = ALT_W + 2;
	localparam int TGT_W      = BASE_W + FRAC_BITS + 1;
	localparam int MAG_W      = TGT_W - 1;
	localparam int ACC_W      = MAG_W + GAIN_W;
	localparam int MPL_W      = STEP_W;
	localparam int LIM_W      = VLIM_W + CORR_SHIFT;
	localparam int TOT_W      = CLIMB_W + CORR_SHIFT;
	localparam int BAND_SUM_W = RANGE_W + 2;
	localparam int CNT_W      = $clog2(DIV_W);

	// input tdata layout
	localparam int NOW_LSB     = 0;
	localparam int RATE_LSB    = NOW_LSB + TIME_W;
	localparam int STEP_LSB    = RATE_LSB + RATE_W;
	localparam int RANGE_LSB   = STEP_LSB + STEP_W;
	localparam int NAV_LSB     = RANGE_LSB + RANGE_W;
	localparam int TGT_LSB     = NAV_LSB + ALT_W;
	localparam int LIM_LO_BIT  = TGT_LSB + ALT_W;
	localparam int LIM_HI_BIT  = LIM_LO_BIT + 1;
	localparam int IN_BITS     = LIM_HI_BIT + 1;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CLIMB_W + 7) / 8) * 8;

	// configuration registers
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VLIM       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BAND_BELOW = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ABOVE = CFG_IDX_W'(4);

	localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(3277);
	localparam logic [VLIM_W-1:0] VLIM_RST    = VLIM_W'(150);
	localparam logic [TMO_W-1:0]  TIMEOUT_RST = TMO_W'(1000);
	localparam logic [BAND_W-1:0] BAND_RST    = BAND_W'(100);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_MUL,
		ST_DIV,
		ST_MOVE,
		ST_CLAMP,
		ST_ERR,
		ST_ABS,
		ST_GAIN,
		ST_SAT,
		ST_TOT,
		ST_RES
	} state_t;

endpackage

FILE: rtl/surface_tracking_climb_rate.sv
// Surface tracking climb rate controller.
// One transfer on the s_axis channel is one controller call; it returns exactly
// one transfer on m_axis carrying the corrected climb rate in cm/s.
// Gains, limits, timeout and clamp band are set through the cfg channel, which
// is always ready; write it only while no call is in flight.
// A call whose target moves runs, from the input transfer to the registered
// result, a bit-serial rate-by-step multiply over the 20 step bits, a restoring
// divide by 10^6 over the 44 product and fraction bits, and a bit-serial gain
// multiply over the 14 gain bits. With zero pilot rate or a throttle limit in
// that direction the move is skipped. One call is worked on at a time; the next
// can be taken in the cycle after the result is loaded into the output
// register.
// Reset clears the tracking target and the last call time to zero and loads the
// default register values; the output register comes up empty.
// A stalled receiver holds the result in the output register; the block then
// waits with its finished result until the output register frees up.
module surface_tracking_climb_rate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// now_ms, pilot_rate, step_us, range_alt_cm, nav_alt_cm, alt_target_cm,
	// limit_low, limit_high, zero pad
	input  logic [stcr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// climb_rate, zero pad
	output logic [stcr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	stcr_pkg::state_t state_q, state_d;

	// configuration
	logic [stcr_pkg::GAIN_W-1:0] gain_q;
	logic [stcr_pkg::VLIM_W-1:0] vlim_q;
	logic [stcr_pkg::TMO_W-1:0]  timeout_q;
	logic [stcr_pkg::BAND_W-1:0] below_q;
	logic [stcr_pkg::BAND_W-1:0] above_q;

	// persistent state
	logic [stcr_pkg::TIME_W-1:0] last_time_q;
	logic [stcr_pkg::TGT_W-1:0]  target_q;

	// captured call
	logic [stcr_pkg::TIME_W-1:0]  now_q;
	logic [stcr_pkg::RATE_W-1:0]  rate_q;
	logic [stcr_pkg::RANGE_W-1:0] range_q;
	logic [stcr_pkg::ALT_W-1:0]   nav_q;
	logic [stcr_pkg::ALT_W-1:0]   tgt_q;
	logic                         lim_lo_q;
	logic                         lim_hi_q;

	// serial datapath
	logic [stcr_pkg::BASE_W-1:0]  base_q;
	logic [stcr_pkg::ACC_W-1:0]   acc_q;
	logic [stcr_pkg::MAG_W-1:0]   mcand_q;
	logic [stcr_pkg::MPL_W-1:0]   mpl_q;
	logic [stcr_pkg::REM_W-1:0]   rem_q;
	logic [stcr_pkg::CNT_W-1:0]   cnt_q;
	logic [stcr_pkg::TGT_W-1:0]   err_q;
	logic                         neg_q;
	logic [stcr_pkg::LIM_W-1:0]   sat_q;
	logic [stcr_pkg::TOT_W-1:0]   total_q;

	logic                          out_valid_q;
	logic [stcr_pkg::CLIMB_W-1:0]  out_data_q;

	logic                          in_xfer;
	logic                          out_free;
	logic                          load_out;
	logic                          cnt_done;

	logic [stcr_pkg::BASE_W-1:0]     base_c;
	logic [stcr_pkg::TGT_W-1:0]      seed_c;
	logic [stcr_pkg::TGT_W-1:0]      base_sh_c;
	logic [stcr_pkg::TIME_W-1:0]     gap_c;
	logic                            reseed_c;
	logic                            rate_neg_c;
	logic                            rate_pos_c;
	logic                            move_c;
	logic [stcr_pkg::RATE_W-1:0]     rate_mag_c;
	logic [stcr_pkg::ACC_W-1:0]      mul_next_c;
	logic [stcr_pkg::REM_W:0]        rem2_c;
	logic [stcr_pkg::REM_W:0]        rem_sub_c;
	logic                            div_ge_c;
	logic [stcr_pkg::TGT_W-1:0]      quo_c;
	logic [stcr_pkg::TGT_W-1:0]      moved_c;
	logic [stcr_pkg::BAND_SUM_W-1:0] lo_c;
	logic [stcr_pkg::BAND_SUM_W-1:0] hi_c;
	logic [stcr_pkg::TGT_W-1:0]      lo_sh_c;
	logic [stcr_pkg::TGT_W-1:0]      hi_sh_c;
	logic [stcr_pkg::TGT_W-1:0]      clamped_c;
	logic [stcr_pkg::TGT_W-1:0]      err_abs_c;
	logic [stcr_pkg::LIM_W-1:0]      lim_c;
	logic [stcr_pkg::TOT_W-1:0]      rate_sh_c;
	logic [stcr_pkg::TOT_W-1:0]      sat_ext_c;
	logic [stcr_pkg::CLIMB_W-1:0]    res_c;

	assign s_axis_tready = (state_q == stcr_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign load_out      = (state_q == stcr_pkg::ST_RES) && out_free;
	assign cnt_done      = (cnt_q == '0);
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(stcr_pkg::OUT_TDATA_W - stcr_pkg::CLIMB_W){1'b0}}, out_data_q};

	// range + alt target - nav altitude, the offset between both references
	assign base_c = {{(stcr_pkg::BASE_W - stcr_pkg::RANGE_W){1'b0}}, range_q}
		+ {{(stcr_pkg::BASE_W - stcr_pkg::ALT_W){tgt_q[stcr_pkg::ALT_W-1]}}, tgt_q}
		- {{(stcr_pkg::BASE_W - stcr_pkg::ALT_W){nav_q[stcr_pkg::ALT_W-1]}}, nav_q};
	assign seed_c = {base_c[stcr_pkg::BASE_W-1], base_c, {stcr_pkg::FRAC_BITS{1'b0}}};
	assign base_sh_c = {base_q[stcr_pkg::BASE_W-1], base_q, {stcr_pkg::FRAC_BITS{1'b0}}};

	// wrapping gap since the previous call
	assign gap_c    = now_q - last_time_q;
	assign reseed_c = gap_c > {{(stcr_pkg::TIME_W - stcr_pkg::TMO_W){1'b0}}, timeout_q};

	assign rate_neg_c = rate_q[stcr_pkg::RATE_W-1];
	assign rate_pos_c = !rate_neg_c && (|rate_q);
	assign move_c     = (rate_neg_c && !lim_lo_q) || (rate_pos_c && !lim_hi_q);
	assign rate_mag_c = rate_neg_c ? -rate_q : rate_q;

	// msb-first shift and add, shared by both multiplies
	assign mul_next_c = {acc_q[stcr_pkg::ACC_W-2:0], 1'b0}
		+ (mpl_q[stcr_pkg::MPL_W-1]
			? {{(stcr_pkg::ACC_W - stcr_pkg::MAG_W){1'b0}}, mcand_q}
			: {stcr_pkg::ACC_W{1'b0}});

	// restoring divide by 10^6, quotient bits shift in at the bottom of acc
	assign rem2_c    = {rem_q, acc_q[stcr_pkg::DIV_W-1]};
	assign div_ge_c  = rem2_c >= (stcr_pkg::REM_W + 1)'(stcr_pkg::US_PER_S);
	assign rem_sub_c = rem2_c - (stcr_pkg::REM_W + 1)'(stcr_pkg::US_PER_S);

	assign quo_c   = {1'b0, acc_q[stcr_pkg::TGT_W-2:0]};
	assign moved_c = rate_neg_c ? (target_q - quo_c) : (target_q + quo_c);

	assign lo_c = {{(stcr_pkg::BAND_SUM_W - stcr_pkg::RANGE_W){1'b0}}, range_q}
		- {{(stcr_pkg::BAND_SUM_W - stcr_pkg::BAND_W){1'b0}}, below_q};
	assign hi_c = {{(stcr_pkg::BAND_SUM_W - stcr_pkg::RANGE_W){1'b0}}, range_q}
		+ {{(stcr_pkg::BAND_SUM_W - stcr_pkg::BAND_W){1'b0}}, above_q};
	assign lo_sh_c = {{(stcr_pkg::TGT_W - stcr_pkg::BAND_SUM_W - stcr_pkg::FRAC_BITS)
		{lo_c[stcr_pkg::BAND_SUM_W-1]}}, lo_c, {stcr_pkg::FRAC_BITS{1'b0}}};
	assign hi_sh_c = {{(stcr_pkg::TGT_W - stcr_pkg::BAND_SUM_W - stcr_pkg::FRAC_BITS)
		{hi_c[stcr_pkg::BAND_SUM_W-1]}}, hi_c, {stcr_pkg::FRAC_BITS{1'b0}}};

	always_comb begin
		if ($signed(target_q) < $signed(lo_sh_c)) begin
			clamped_c = lo_sh_c;
		end else if ($signed(target_q) > $signed(hi_sh_c)) begin
			clamped_c = hi_sh_c;
		end else begin
			clamped_c = target_q;
		end
	end

	assign err_abs_c = err_q[stcr_pkg::TGT_W-1] ? -err_q : err_q;

	assign lim_c     = {vlim_q, {stcr_pkg::CORR_SHIFT{1'b0}}};
	assign rate_sh_c = {{(stcr_pkg::TOT_W - stcr_pkg::RATE_W - stcr_pkg::CORR_SHIFT)
		{rate_q[stcr_pkg::RATE_W-1]}}, rate_q, {stcr_pkg::CORR_SHIFT{1'b0}}};
	assign sat_ext_c = {{(stcr_pkg::TOT_W - stcr_pkg::LIM_W){1'b0}}, sat_q};

	// floor, then step up for negative totals with a nonzero fraction
	assign res_c = total_q[stcr_pkg::TOT_W-1:stcr_pkg::CORR_SHIFT]
		+ {{(stcr_pkg::CLIMB_W - 1){1'b0}},
			(total_q[stcr_pkg::TOT_W-1] && (|total_q[stcr_pkg::CORR_SHIFT-1:0]))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stcr_pkg::ST_IDLE: begin
				if (in_xfer) state_d = stcr_pkg::ST_SEED;
			end
			stcr_pkg::ST_SEED: begin
				state_d = move_c ? stcr_pkg::ST_MUL : stcr_pkg::ST_CLAMP;
			end
			stcr_pkg::ST_MUL: begin
				if (cnt_done) state_d = stcr_pkg::ST_DIV;
			end
			stcr_pkg::ST_DIV: begin
				if (cnt_done) state_d = stcr_pkg::ST_MOVE;
			end
			stcr_pkg::ST_MOVE:  state_d = stcr_pkg::ST_CLAMP;
			stcr_pkg::ST_CLAMP: state_d = stcr_pkg::ST_ERR;
			stcr_pkg::ST_ERR:   state_d = stcr_pkg::ST_ABS;
			stcr_pkg::ST_ABS:   state_d = stcr_pkg::ST_GAIN;
			stcr_pkg::ST_GAIN: begin
				if (cnt_done) state_d = stcr_pkg::ST_SAT;
			end
			stcr_pkg::ST_SAT: state_d = stcr_pkg::ST_TOT;
			stcr_pkg::ST_TOT: state_d = stcr_pkg::ST_RES;
			stcr_pkg::ST_RES: begin
				if (out_free) state_d = stcr_pkg::ST_IDLE;
			end
			default: state_d = stcr_pkg::ST_IDLE;
		endcase
	end

	// registers set by reset: configuration to defaults, tracking state and output valid cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= stcr_pkg::GAIN_RST;
			vlim_q      <= stcr_pkg::VLIM_RST;
			timeout_q   <= stcr_pkg::TIMEOUT_RST;
			below_q     <= stcr_pkg::BAND_RST;
			above_q     <= stcr_pkg::BAND_RST;
			last_time_q <= '0;
			target_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					stcr_pkg::REG_GAIN:       gain_q    <= cfg_data[stcr_pkg::GAIN_W-1:0];
					stcr_pkg::REG_VLIM:       vlim_q    <= cfg_data[stcr_pkg::VLIM_W-1:0];
					stcr_pkg::REG_TIMEOUT:    timeout_q <= cfg_data[stcr_pkg::TMO_W-1:0];
					stcr_pkg::REG_BAND_BELOW: below_q   <= cfg_data[stcr_pkg::BAND_W-1:0];
					stcr_pkg::REG_BAND_ABOVE: above_q   <= cfg_data[stcr_pkg::BAND_W-1:0];
					default: ;
				endcase
			end
			if (state_q == stcr_pkg::ST_SEED) begin
				last_time_q <= now_q;
				if (reseed_c) target_q <= seed_c;
			end
			if (state_q == stcr_pkg::ST_MOVE) target_q <= moved_c;
			if (state_q == stcr_pkg::ST_CLAMP) target_q <= clamped_c;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and serial datapath
	always_ff @(posedge clk) begin
		if (load_out) out_data_q <= res_c;
		unique case (state_q)
			stcr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					now_q    <= s_axis_tdata[stcr_pkg::NOW_LSB +: stcr_pkg::TIME_W];
					rate_q   <= s_axis_tdata[stcr_pkg::RATE_LSB +: stcr_pkg::RATE_W];
					mpl_q    <= s_axis_tdata[stcr_pkg::STEP_LSB +: stcr_pkg::STEP_W];
					range_q  <= s_axis_tdata[stcr_pkg::RANGE_LSB +: stcr_pkg::RANGE_W];
					nav_q    <= s_axis_tdata[stcr_pkg::NAV_LSB +: stcr_pkg::ALT_W];
					tgt_q    <= s_axis_tdata[stcr_pkg::TGT_LSB +: stcr_pkg::ALT_W];
					lim_lo_q <= s_axis_tdata[stcr_pkg::LIM_LO_BIT];
					lim_hi_q <= s_axis_tdata[stcr_pkg::LIM_HI_BIT];
				end
			end
			stcr_pkg::ST_SEED: begin
				base_q  <= base_c;
				mcand_q <= {{(stcr_pkg::MAG_W - stcr_pkg::RATE_W){1'b0}}, rate_mag_c};
				acc_q   <= '0;
				cnt_q   <= stcr_pkg::CNT_W'(stcr_pkg::STEP_W - 1);
			end
			stcr_pkg::ST_MUL: begin
				mpl_q <= {mpl_q[stcr_pkg::MPL_W-2:0], 1'b0};
				if (cnt_done) begin
					// append the fraction bits to the dividend
					acc_q <= mul_next_c << stcr_pkg::FRAC_BITS;
					rem_q <= '0;
					cnt_q <= stcr_pkg::CNT_W'(stcr_pkg::DIV_W - 1);
				end else begin
					acc_q <= mul_next_c;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			stcr_pkg::ST_DIV: begin
				acc_q <= {acc_q[stcr_pkg::ACC_W-2:0], div_ge_c};
				rem_q <= div_ge_c ? rem_sub_c[stcr_pkg::REM_W-1:0]
					: rem2_c[stcr_pkg::REM_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			stcr_pkg::ST_MOVE: ;
			stcr_pkg::ST_CLAMP: ;
			stcr_pkg::ST_ERR: begin
				err_q <= target_q - base_sh_c;
			end
			stcr_pkg::ST_ABS: begin
				neg_q   <= err_q[stcr_pkg::TGT_W-1];
				mcand_q <= err_abs_c[stcr_pkg::MAG_W-1:0];
				mpl_q   <= {gain_q, {(stcr_pkg::MPL_W - stcr_pkg::GAIN_W){1'b0}}};
				acc_q   <= '0;
				cnt_q   <= stcr_pkg::CNT_W'(stcr_pkg::GAIN_W - 1);
			end
			stcr_pkg::ST_GAIN: begin
				acc_q <= mul_next_c;
				mpl_q <= {mpl_q[stcr_pkg::MPL_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			stcr_pkg::ST_SAT: begin
				if (acc_q > {{(stcr_pkg::ACC_W - stcr_pkg::LIM_W){1'b0}}, lim_c}) begin
					sat_q <= lim_c;
				end else begin
					sat_q <= acc_q[stcr_pkg::LIM_W-1:0];
				end
			end
			stcr_pkg::ST_TOT: begin
				total_q <= neg_q ? (rate_sh_c - sat_ext_c) : (rate_sh_c + sat_ext_c);
			end
			stcr_pkg::ST_RES: ;
			default: ;
		endcase
	end

endmodule

FILE: rtl/stcr_checker.sv
module stcr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [stcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one call in flight at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a call is in flight");

	// even the shortest call keeps the input closed this long
	a_min_call: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##20 !s_axis_tready)
		else $error("call finished too early");

	// a new result only shows up at the end of a call
	a_result_from_call: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while idle");

endmodule

bind surface_tracking_climb_rate stcr_checker u_stcr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
